/* rtl/core/utf8sa_pkg.sv */
// shared constants, types and helpers of the utf-8 sanitizer
package utf8sa_pkg;

  localparam int unsigned CAP_W    = 11;
  localparam int unsigned MAX_OUT  = 8;
  localparam int unsigned PEND_MAX = 3;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  typedef enum logic {
    CFG_STRIP_SLASH = 1'b0,
    CFG_CAPACITY    = 1'b1
  } cfg_index_t;

  // one buffered group of output beats
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [3:0]              count;
    logic                    has_bytes;
    logic                    eos;
    logic                    trunc;
  } slot_t;

  // total length of a multi-byte form from its lead byte, 0 if not a lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    if ((b & 8'hE0) == 8'hC0) return 3'd2;
    if ((b & 8'hF0) == 8'hE0) return 3'd3;
    if ((b & 8'hF8) == 8'hF0) return 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [7:0] latin1_hi(input logic [7:0] b);
    return 8'hC0 | {6'd0, b[7:6]};
  endfunction

  function automatic logic [7:0] latin1_lo(input logic [7:0] b);
    return 8'h80 | {2'd0, b[5:0]};
  endfunction

endpackage

/* rtl/core/utf8_sanitize_append.sv */
// utf8_sanitize_append: utf-8 pass-through with latin-1 fallback and capacity cutoff
//
// s_axis carries one source byte per beat: tdata is the byte, tuser says the
// beat holds a byte, tlast marks the end of the string. m_axis carries one
// output byte per beat: tlast marks the last beat caused by an input beat,
// tuser holds byte_valid, string_done and truncated.
// cfg is a write channel (index, data) that is always ready; index 0 sets
// slash stripping, index 1 sets the capacity and reloads the remaining room.
// An input beat is processed in the cycle it is accepted; its output beats
// are registered into a buffer entry and offered once older entries are sent.
// Each input beat yields 0 to 8 output beats, sent one per cycle from a
// two-entry result buffer while the receiver is ready, so the block takes
// one input beat per cycle while an entry is free, and the sustained rate
// is set by the output port: a latin-1 byte yields two output beats and an
// ascii byte one.
// When the receiver stalls, the current beat holds and input stalls once
// both buffer entries are full. Reset clears the lookahead, the stop flag
// and the buffer, restores the register defaults and reloads the room.
module utf8_sanitize_append #(
  parameter int unsigned MAX_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [2:0]  m_axis_tuser,   // byte_valid, string_done, truncated
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import utf8sa_pkg::*;

  localparam int unsigned RW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned CW = (RW > CAP_W) ? RW : CAP_W;
  localparam int unsigned RESET_ROOM = (MAX_CAPACITY < 1024) ? MAX_CAPACITY : 1024;

  function automatic logic [RW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    if (CW'(c) > CW'(MAX_CAPACITY)) return RW'(MAX_CAPACITY);
    return RW'(c);
  endfunction

  logic             strip_slash;
  logic [CAP_W-1:0] capacity_bytes;
  logic [7:0]       pending_bytes [PEND_MAX];
  logic [1:0]       pending_count;
  logic [RW-1:0]    room_left;
  logic             stopped;

  slot_t      slot [2];
  logic [1:0] slot_full;
  logic [1:0] slot_full_next;
  logic       wr_ptr, rd_ptr;
  logic [2:0] rd_idx;

  logic             in_beat, out_beat, out_done;
  logic             cap_write;
  logic [7:0]       pending_bytes_next [PEND_MAX];
  logic [1:0]       pending_count_next;
  logic [RW-1:0]    room_left_next;
  logic             stopped_next;
  logic             slot_write;
  slot_t            slot_next;

  always_comb begin
    logic [7:0]  v;
    logic        has, eos, cont, complete, append, fresh;
    logic        is_slash, is_ascii, is_lead, dir_ok, stop_now, stopped_after;
    logic [2:0]  need, lc, dl, k;
    logic [7:0]  lb [4];
    logic [7:0]  d [4];
    logic [CW-1:0] room_ext, rem;
    logic [3:0]  n, jj;
    logic [7:0]  pair_byte;

    v   = s_axis_tdata;
    has = s_axis_tuser;
    eos = s_axis_tlast;
    pending_bytes_next = pending_bytes;

    need     = seq_len(pending_bytes[0]);
    cont     = has && (pending_count != 2'd0) && (v[7:6] == 2'b10);
    complete = cont && (({1'b0, pending_count} + 3'd1) >= need);
    append   = cont && !complete;
    fresh    = has && !cont;
    is_slash = strip_slash && (v == SLASH_CHAR);
    is_ascii = !v[7];
    is_lead  = (seq_len(v) != 3'd0);

    // latin-1 run: pending bytes, then possibly the new byte
    for (int i = 0; i < 3; i++) begin
      lb[i] = (2'(i) < pending_count) ? pending_bytes[i] : v;
      d[i]  = (complete && 2'(i) < pending_count) ? pending_bytes[i] : v;
    end
    lb[3] = v;
    d[3]  = v;

    lc = 3'd0;
    dl = 3'd0;
    if (stopped) begin
      lc = 3'd0;
    end else if (append) begin
      lc = eos ? ({1'b0, pending_count} + 3'd1) : 3'd0;
    end else if (complete) begin
      dl = {1'b0, pending_count} + 3'd1;
    end else if (fresh) begin
      lc = {1'b0, pending_count} +
           ((!is_slash && !is_ascii && (!is_lead || eos)) ? 3'd1 : 3'd0);
      dl = (!is_slash && is_ascii) ? 3'd1 : 3'd0;
    end else begin
      lc = eos ? {1'b0, pending_count} : 3'd0;
    end

    // latin-1 characters that fit form a prefix of the run
    room_ext = CW'(room_left);
    k = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < lc && room_ext >= CW'(2 * (i + 1))) k = 3'(i + 1);
    end
    rem      = room_ext - CW'({k, 1'b0});
    dir_ok   = (dl != 3'd0) && (k == lc) && (rem >= CW'(dl));
    stop_now = !stopped && ((k != lc) || ((dl != 3'd0) && !dir_ok));
    stopped_after = stopped || stop_now;
    n = {k, 1'b0} + (dir_ok ? {1'b0, dl} : 4'd0);

    for (int j = 0; j < MAX_OUT; j++) begin
      jj = 4'(j) - {k, 1'b0};
      pair_byte = (j % 2 == 0) ? latin1_hi(lb[j / 2]) : latin1_lo(lb[j / 2]);
      slot_next.bytes[j] = (4'(j) < {k, 1'b0}) ? pair_byte : d[jj[1:0]];
    end
    if (n == 4'd0) slot_next.bytes[0] = 8'd0;
    slot_next.count     = (n != 4'd0) ? n : 4'd1;
    slot_next.has_bytes = (n != 4'd0);
    slot_next.eos       = eos;
    slot_next.trunc     = stopped_after;
    slot_write          = in_beat && ((n != 4'd0) || eos);

    pending_count_next = pending_count;
    if (eos || stopped_after || complete) begin
      pending_count_next = 2'd0;
    end else if (append) begin
      pending_bytes_next[pending_count] = v;
      pending_count_next = pending_count + 2'd1;
    end else if (fresh) begin
      if (!is_slash && is_lead) begin
        pending_bytes_next[0] = v;
        pending_count_next = 2'd1;
      end else begin
        pending_count_next = 2'd0;
      end
    end

    room_left_next = eos ? clamp_cap(capacity_bytes) : RW'(rem - (dir_ok ? CW'(dl) : '0));
    stopped_next   = eos ? 1'b0 : stopped_after;
  end

  assign s_axis_tready = !slot_full[wr_ptr];
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cap_write     = cfg_valid && cfg_ready && (cfg_index_t'(cfg_index) == CFG_CAPACITY);

  assign m_axis_tvalid = slot_full[rd_ptr];
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tlast  = ({1'b0, rd_idx} == (slot[rd_ptr].count - 4'd1));
  assign out_done      = out_beat && m_axis_tlast;
  assign m_axis_tdata  = slot[rd_ptr].bytes[rd_idx];
  assign m_axis_tuser  = {slot[rd_ptr].trunc, slot[rd_ptr].eos && m_axis_tlast,
                          slot[rd_ptr].has_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_slash    <= 1'b0;
      capacity_bytes <= CAP_W'(1024);
      pending_count  <= 2'd0;
      room_left      <= RW'(RESET_ROOM);
      stopped        <= 1'b0;
      for (int i = 0; i < PEND_MAX; i++) pending_bytes[i] <= 8'd0;
    end else begin
      if (in_beat) begin
        pending_bytes <= pending_bytes_next;
        pending_count <= pending_count_next;
        stopped       <= in_beat ? stopped_next : stopped;
      end
      // a capacity write reloads the room
      if (cap_write) begin
        room_left <= clamp_cap(cfg_data);
      end else if (in_beat) begin
        room_left <= room_left_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_STRIP_SLASH: strip_slash <= cfg_data[0];
          CFG_CAPACITY:    capacity_bytes <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    slot_full_next = slot_full;
    if (slot_write) slot_full_next[wr_ptr] = 1'b1;
    if (out_done) slot_full_next[rd_ptr] = 1'b0;
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= 2'b00;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      rd_idx    <= 3'd0;
    end else begin
      slot_full <= slot_full_next;
      if (slot_write) begin
        wr_ptr <= !wr_ptr;
      end
      if (out_done) begin
        rd_ptr <= !rd_ptr;
        rd_idx <= 3'd0;
      end else if (out_beat) begin
        rd_idx <= rd_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_write) slot[wr_ptr] <= slot_next;
  end

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (slot_full == 2'b11) |-> !s_axis_tready)
    else $error("input accepted with result buffer full");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (slot[rd_ptr].count != 4'd0))
    else $error("result entry holds no beats");

  a_last_advances: assert property (@(posedge clk) disable iff (rst)
    out_done |=> (rd_ptr != $past(rd_ptr)) && (rd_idx == 3'd0))
    else $error("read side did not advance after last beat");

  a_room_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(room_left) <= CW'(MAX_CAPACITY))
    else $error("room exceeds capacity limit");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, rd_idx} < slot[rd_ptr].count))
    else $error("beat index past entry count");

endmodule

/* verif/utf8_sanitize_append_tb.sv */
// self-checking testbench for the utf-8 sanitizer with latin-1 fallback
`timescale 1ns / 100ps

module utf8_sanitize_append_tb;
  import utf8sa_pkg::*;

  localparam int unsigned MAX_CAPACITY = 1024;
  localparam int unsigned RAND_ITEMS   = 90;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
    logic       truncated;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = 11'd0;

  utf8_sanitize_append #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // data_byte
    .s_axis_tuser (s_axis_tuser),   // has_byte
    .s_axis_tlast (s_axis_tlast),   // end_of_string
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // out_byte
    .m_axis_tuser (m_axis_tuser),   // byte_valid, string_done, truncated
    .m_axis_tlast (m_axis_tlast),   // last_of_run
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  src_item_t   src_items[$];
  out_beat_t   expected_bytes[$];
  int unsigned src_sent = 0;
  int unsigned src_taken = 0;
  int unsigned rand_items = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // sanitizer shadow state
  logic [7:0]  la_byte [3] = '{default: 8'h00};
  int unsigned la_cnt = 0;
  int unsigned room_left = MAX_CAPACITY;
  bit          out_stopped = 1'b0;
  bit          strip_on = 1'b0;
  logic [10:0] cap_reg = 11'd1024;
  logic [7:0]  step_buf [8];
  int unsigned step_n;

  // sender burst and receiver stall pattern state
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_cap(input logic [10:0] c);
    return (c > MAX_CAPACITY) ? MAX_CAPACITY : c;
  endfunction

  function automatic int unsigned form_len(input logic [7:0] v);
    casez (v)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // a whole character goes out only if all of its bytes fit
  task automatic put_char(input logic [31:0] chr, input int unsigned n);
    if (out_stopped) return;
    if (n > room_left) begin
      out_stopped = 1'b1;
      la_cnt = 0;
      return;
    end
    room_left = room_left - n;
    for (int i = 0; i < n; i++) begin
      if (step_n < 8) begin
        step_buf[step_n] = chr[8*i +: 8];
        step_n++;
      end
    end
  endtask

  task automatic put_latin1(input logic [7:0] v);
    put_char({16'h0000, 2'b10, v[5:0], 6'b110000, v[7:6]}, 2);
  endtask

  task automatic resolve_la();
    logic [7:0]  held [3];
    int unsigned n;
    n = la_cnt;
    held = la_byte;
    la_cnt = 0;
    for (int i = 0; i < n; i++) put_latin1(held[i]);
  endtask

  task automatic sanitize_step(input logic [7:0] v, input logic has, input logic eos);
    logic [31:0] chr;
    step_n = 0;
    if (has && !out_stopped) begin
      if (la_cnt > 0 && v[7:6] == 2'b10) begin
        if (la_cnt + 1 >= form_len(la_byte[0])) begin
          chr = 32'h0;
          for (int i = 0; i < la_cnt; i++) chr[8*i +: 8] = la_byte[i];
          chr[8*la_cnt +: 8] = v;
          put_char(chr, la_cnt + 1);
          la_cnt = 0;
        end else begin
          la_byte[la_cnt] = v;
          la_cnt++;
        end
      end else begin
        resolve_la();
        if (!out_stopped && !(strip_on && v == SLASH_CHAR)) begin
          if (v < 8'h80) begin
            put_char({24'h0, v}, 1);
          end else if (form_len(v) != 0) begin
            la_byte[0] = v;
            la_cnt = 1;
          end else begin
            put_latin1(v);
          end
        end
      end
    end
    if (eos && !out_stopped) resolve_la();

    if (step_n == 0 && eos) begin
      expected_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1, out_stopped});
    end else begin
      for (int k = 0; k < step_n; k++) begin
        expected_bytes.push_back('{step_buf[k], 1'b1, k == step_n - 1,
                                   eos && (k == step_n - 1), out_stopped});
      end
    end

    // a new string starts clean
    if (eos) begin
      la_cnt = 0;
      la_byte = '{default: 8'h00};
      out_stopped = 1'b0;
      room_left = clamp_cap(cap_reg);
    end
  endtask

  task automatic push_item(input logic [7:0] d, input logic has, input logic eos);
    src_items.push_back('{d, has, eos});
    rand_items++;
  endtask

  function automatic logic [7:0] lead_of(input int unsigned len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic gen_char(input bit eos);
    int unsigned len;
    int unsigned conts;
    case ($urandom_range(0, 11))
      0, 1: push_item(8'($urandom_range(0, 127)), 1'b1, eos);
      2:    push_item(SLASH_CHAR, 1'b1, eos);
      3, 4, 5, 6: begin
        len = $urandom_range(2, 4);
        push_item(lead_of(len), 1'b1, 1'b0);
        for (int i = 1; i < len; i++)
          push_item(8'h80 | 8'($urandom_range(0, 63)), 1'b1, eos && (i == len - 1));
      end
      7: begin
        // lead cut short by whatever follows
        len = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        push_item(lead_of(len), 1'b1, eos && (conts == 0));
        for (int i = 1; i <= conts; i++)
          push_item(8'h80 | 8'($urandom_range(0, 63)), 1'b1, eos && (i == conts));
      end
      8:  push_item(8'h80 | 8'($urandom_range(0, 63)), 1'b1, eos);
      9:  push_item(8'($urandom_range(8'hF8, 8'hFF)), 1'b1, eos);
      10: push_item(8'($urandom_range(128, 255)), 1'b1, eos);
      default: push_item(8'($urandom_range(0, 255)), 1'b0, eos);
    endcase
  endtask

  task automatic gen_string();
    int unsigned n_chars;
    bit          bare_end;
    n_chars = $urandom_range(1, 10);
    bare_end = ($urandom_range(0, 2) == 0);
    for (int c = 0; c < n_chars; c++) gen_char(!bare_end && (c == n_chars - 1));
    if (bare_end) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [10:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    while (src_items.size() != 0 || src_sent != src_taken || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : src_drive
    src_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (src_sent == src_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (src_items.size() > 0) begin
        it = src_items.pop_front();
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= it.has;
        s_axis_tlast  <= it.eos;
        s_axis_tvalid <= 1'b1;
        src_sent++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink_pattern
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 99) < 45);
      default: m_axis_tready <= (rx_tick % 4 == 0);
    endcase
  end

  always @(posedge clk) begin : out_monitor
    out_beat_t got;
    out_beat_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STRIP_SLASH) begin
          strip_on = cfg_data[0];
        end else begin
          cap_reg = cfg_data;
          room_left = clamp_cap(cfg_data);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sanitize_step(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        src_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1], m_axis_tuser[2]};
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output beat: byte %h valid %b last %b done %b trunc %b",
                     got.out_byte, got.byte_valid, got.last_of_run, got.string_done,
                     got.truncated);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"output beat mismatch: expected byte %h valid %b last %b done %b ",
                        "trunc %b, got byte %h valid %b last %b done %b trunc %b"},
                       want.out_byte, want.byte_valid, want.last_of_run, want.string_done,
                       want.truncated, got.out_byte, got.byte_valid, got.last_of_run,
                       got.string_done, got.truncated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("utf8_sanitize_append test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [10:0] cap_val;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pass-through, latin-1 fallback, broken lead, empty item, end with pending lead
    write_reg(CFG_STRIP_SLASH, 11'd0);
    write_reg(CFG_CAPACITY, 11'd1024);
    @(posedge clk);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(SLASH_CHAR, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hC3, 1'b1, 1'b0);
    push_item(8'hA9, 1'b1, 1'b0);
    push_item(8'hE2, 1'b1, 1'b0);
    push_item(8'h82, 1'b1, 1'b0);
    push_item(8'hAC, 1'b1, 1'b0);
    push_item(8'hF0, 1'b1, 1'b0);
    push_item(8'h9F, 1'b1, 1'b0);
    push_item(8'h98, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'hE2, 1'b1, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'hF0, 1'b1, 1'b0);
    push_item(8'h9F, 1'b1, 1'b0);
    push_item(8'h98, 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    settle();

    // stripped slash breaks a sequence, oversized capacity clamps
    write_reg(CFG_STRIP_SLASH, 11'd1);
    write_reg(CFG_CAPACITY, 11'd2047);
    @(posedge clk);
    push_item(8'hC3, 1'b1, 1'b0);
    push_item(SLASH_CHAR, 1'b1, 1'b0);
    push_item(8'hA9, 1'b1, 1'b1);
    settle();

    // character that does not fit, later bytes dropped
    write_reg(CFG_STRIP_SLASH, 11'd0);
    write_reg(CFG_CAPACITY, 11'd3);
    @(posedge clk);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'hE2, 1'b1, 1'b0);
    push_item(8'h82, 1'b1, 1'b0);
    push_item(8'hAC, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b1);
    settle();

    write_reg(CFG_CAPACITY, 11'd0);
    @(posedge clk);
    push_item(8'h41, 1'b1, 1'b1);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      write_reg(CFG_STRIP_SLASH, 11'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
        0:       cap_val = 11'd0;
        1:       cap_val = 11'($urandom_range(1, 4));
        2:       cap_val = 11'($urandom_range(5, 30));
        3:       cap_val = 11'd1024;
        4:       cap_val = 11'($urandom_range(1025, 2047));
        5:       cap_val = 11'd2047;
        default: cap_val = 11'($urandom_range(0, 60));
      endcase
      write_reg(CFG_CAPACITY, cap_val);
      @(posedge clk);
      repeat ($urandom_range(1, 3)) gen_string();
    end
    settle();

    if (mismatches == 0) begin
      $display("utf8_sanitize_append test passed");
    end else begin
      $display("utf8_sanitize_append test failed");
    end
    $finish;
  end

endmodule

/* utf8_sanitize_append.f */
rtl/core/utf8sa_pkg.sv
rtl/core/utf8_sanitize_append.sv
verif/utf8_sanitize_append_tb.sv
